// File: rtl/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types, constants and register codes of the multi-voice sample mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

   // parameter defaults
   localparam int VOICES_DEF       = 4;
   localparam int NUM_SOUNDS_DEF   = 3;
   localparam int SAMPLE_DEPTH_DEF = 65536;

   // field and register widths
   localparam int SOUND_SLOTS = 3;
   localparam int GAIN_W      = 15;
   localparam int START_W     = 16;
   localparam int LENGTH_W    = 17;
   localparam int SAMPLE_W    = 16;
   localparam int PROD_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;
   localparam int SHOWN_VOICES = 4;

   // command queue between front and back
   localparam int CMD_DEPTH = 2;

   localparam int MIX_SHIFT = 15;
   localparam int MIX_LIMIT = 32767;

   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 15'd9830;
   localparam logic [START_W-1:0]  START_RESET  = 16'd0;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 17'd1;

   // action codes
   localparam logic [1:0] ACT_FRAME   = 2'd0;
   localparam logic [1:0] ACT_TRIGGER = 2'd1;
   localparam logic [1:0] ACT_LOAD    = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_S0_START  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_S0_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_S1_START  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_S1_LENGTH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_S2_START  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_S2_LENGTH = 3'd6;

   typedef struct packed {
      logic [1:0]                 action;
      logic [1:0]                 sound_sel;
      logic [15:0]                load_address;
      logic signed [SAMPLE_W-1:0] load_data;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mixed_sample;
      logic [SHOWN_VOICES-1:0]    active_voices;
   } rsp_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [1:0]          sound;
      logic [15:0]         addr;
      logic [SAMPLE_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

   typedef struct packed {
      logic [GAIN_W-1:0]                     gain;
      logic [SOUND_SLOTS-1:0][START_W-1:0]   start;
      logic [SOUND_SLOTS-1:0][LENGTH_W-1:0]  length;
   } cfg_type;

endpackage

// File: rtl/mvsm_ram.sv
// ----------------------------------------------------------------------------
// mvsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mvsm_front.sv
// ----------------------------------------------------------------------------
// mvsm_front
// Accepts requests, drops ones that do nothing and queues the rest for the
// back end.
// ----------------------------------------------------------------------------
module mvsm_front #(
   parameter int NUM_SOUNDS = mvsm_pkg::NUM_SOUNDS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  mvsm_pkg::req_type      req_data,
   output mvsm_pkg::cmd_link_type cmd_out,
   input  logic                   cmd_pop
);

   localparam int PTR_W = (mvsm_pkg::CMD_DEPTH > 1) ? $clog2(mvsm_pkg::CMD_DEPTH) : 1;
   localparam int CNT_W = $clog2(mvsm_pkg::CMD_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL    = CNT_W'(mvsm_pkg::CMD_DEPTH);
   localparam logic [1:0]       SOUND_LIMIT = 2'(NUM_SOUNDS);

   mvsm_pkg::cmd_type fifo_ff [mvsm_pkg::CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic              accept;
   logic              keep;
   logic              do_pop;
   mvsm_pkg::cmd_type cmd_new;

   assign full   = (count_ff == CNT_FULL);
   assign accept = push && !full;
   assign do_pop = cmd_pop && (count_ff != '0);

   // unused action codes and triggers of unknown sounds never reach the queue
   always_comb begin
      keep = 1'b0;
      case (req_data.action)
         mvsm_pkg::ACT_FRAME:   keep = 1'b1;
         mvsm_pkg::ACT_LOAD:    keep = 1'b1;
         mvsm_pkg::ACT_TRIGGER: keep = (req_data.sound_sel < SOUND_LIMIT);
         default:               keep = 1'b0;
      endcase
   end

   assign cmd_new.kind  = req_data.action;
   assign cmd_new.sound = req_data.sound_sel;
   assign cmd_new.addr  = req_data.load_address;
   assign cmd_new.data  = req_data.load_data;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = PTR_W'(rd_ptr_ff + 1'b1);
      end
      case ({accept && keep, do_pop})
         2'b10:   count_in = CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         fifo_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_out.valid = (count_ff != '0);
   assign cmd_out.cmd   = fifo_ff[rd_ptr_ff];

endmodule

// File: rtl/mvsm_back.sv
// ----------------------------------------------------------------------------
// mvsm_back
// Executes queued commands: sample loads, voice triggers and frame mixing
// through one memory read port and one shared multiplier.
// ----------------------------------------------------------------------------
module mvsm_back #(
   parameter int VOICES       = mvsm_pkg::VOICES_DEF,
   parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mvsm_pkg::cfg_type      cfg,
   input  mvsm_pkg::cmd_link_type cmd_in,
   output logic                   cmd_pop,
   output logic                   out_empty,
   input  logic                   out_pop,
   output mvsm_pkg::rsp_type      out_data
);

   localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CNT_W  = $clog2(VOICES + 1);
   localparam int ACC_W  = mvsm_pkg::PROD_W + CNT_W;
   localparam int LEN_W  = mvsm_pkg::LENGTH_W;
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(VOICES);
   localparam logic signed [ACC_W-1:0] POS_LIMIT = ACC_W'(mvsm_pkg::MIX_LIMIT);
   localparam logic signed [ACC_W-1:0] NEG_LIMIT = -POS_LIMIT;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MIX  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [VOICES-1:0] act_ff, act_in;
   logic [1:0]        snd_ff [VOICES];
   logic [1:0]        snd_in [VOICES];
   logic [LEN_W-1:0]  pos_ff [VOICES];
   logic [LEN_W-1:0]  pos_in [VOICES];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              p1_ff, p1_in;
   logic              p2_ff, p2_in;
   logic signed [mvsm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]            acc_ff, acc_in;
   logic              out_vld_ff, out_vld_in;
   mvsm_pkg::rsp_type out_ff, out_in;

   logic [VIDX_W-1:0]                  idx;
   logic [mvsm_pkg::START_W-1:0]       cur_start;
   logic [LEN_W-1:0]                   cur_length;
   logic [LEN_W-1:0]                   pos_next;
   logic [mvsm_pkg::START_W+1:0]       addr_sum;
   logic                               issue;
   logic                               ram_we;
   logic [mvsm_pkg::SAMPLE_W-1:0]      ram_rdata;
   logic signed [mvsm_pkg::PROD_W-1:0] mult;
   logic                               hit;
   logic [VIDX_W-1:0]                  slot;
   logic signed [ACC_W-1:0]            scaled;
   logic signed [ACC_W-1:0]            clamped;
   logic [VOICES+mvsm_pkg::SHOWN_VOICES-1:0] act_pad;

   assign idx = cnt_ff[VIDX_W-1:0];

   // per-voice sound parameters; a sound code past the table plays sound zero
   always_comb begin
      case (snd_ff[idx])
         2'd1: begin
            cur_start  = cfg.start[1];
            cur_length = cfg.length[1];
         end
         2'd2: begin
            cur_start  = cfg.start[2];
            cur_length = cfg.length[2];
         end
         default: begin
            cur_start  = cfg.start[0];
            cur_length = cfg.length[0];
         end
      endcase
   end

   assign pos_next = LEN_W'(pos_ff[idx] + 1'b1);
   assign addr_sum = {2'b00, cur_start} + {1'b0, pos_ff[idx]};
   assign issue    = (state_ff == ST_MIX) && (cnt_ff < CNT_END) && act_ff[idx];
   assign ram_we   = (state_ff == ST_IDLE) && cmd_in.valid
                     && (cmd_in.cmd.kind == mvsm_pkg::ACT_LOAD);

   mvsm_ram #(
      .WIDTH (mvsm_pkg::SAMPLE_W),
      .DEPTH (SAMPLE_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cmd_in.cmd.addr[ADDR_W-1:0]),
      .wr_data (cmd_in.cmd.data),
      .rd_en   (issue),
      .rd_addr (addr_sum[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign mult = $signed(ram_rdata) * $signed({1'b0, cfg.gain});

   // first slot that is idle or already plays the requested sound
   always_comb begin
      hit  = 1'b0;
      slot = '0;
      for (int v = VOICES - 1; v >= 0; v--) begin
         if (!act_ff[v] || (snd_ff[v] == cmd_in.cmd.sound)) begin
            hit  = 1'b1;
            slot = VIDX_W'(v);
         end
      end
   end

   // arithmetic shift is a floor; then clamp symmetric
   assign scaled = acc_ff >>> mvsm_pkg::MIX_SHIFT;
   always_comb begin
      if (scaled > POS_LIMIT) begin
         clamped = POS_LIMIT;
      end else if (scaled < NEG_LIMIT) begin
         clamped = NEG_LIMIT;
      end else begin
         clamped = scaled;
      end
   end

   assign act_pad = {{mvsm_pkg::SHOWN_VOICES{1'b0}}, act_ff};

   always_comb begin
      state_in   = state_ff;
      act_in     = act_ff;
      snd_in     = snd_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      p1_in      = issue;
      p2_in      = p1_ff;
      prod_in    = p1_ff ? mult : prod_ff;
      acc_in     = p2_ff ? (acc_ff + ACC_W'(prod_ff)) : acc_ff;
      out_vld_in = out_vld_ff && !out_pop;
      out_in     = out_ff;
      cmd_pop    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_in.valid) begin
               cmd_pop = 1'b1;
               case (cmd_in.cmd.kind)
                  mvsm_pkg::ACT_FRAME: begin
                     state_in = ST_MIX;
                     cnt_in   = '0;
                     acc_in   = '0;
                  end
                  mvsm_pkg::ACT_TRIGGER: begin
                     if (hit) begin
                        act_in[slot] = 1'b1;
                        snd_in[slot] = cmd_in.cmd.sound;
                        pos_in[slot] = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MIX: begin
            if (cnt_ff < CNT_END) begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
               if (act_ff[idx]) begin
                  pos_in[idx] = pos_next;
                  if (pos_next >= cur_length) begin
                     act_in[idx] = 1'b0;
                  end
               end
            end else if (!p1_ff && !p2_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_vld_ff || out_pop) begin
               out_in.mixed_sample  = clamped[mvsm_pkg::SAMPLE_W-1:0];
               out_in.active_voices = act_pad[mvsm_pkg::SHOWN_VOICES-1:0];
               out_vld_in           = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         act_ff     <= '0;
         cnt_ff     <= '0;
         p1_ff      <= 1'b0;
         p2_ff      <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int v = 0; v < VOICES; v++) begin
            snd_ff[v] <= '0;
            pos_ff[v] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         act_ff     <= act_in;
         cnt_ff     <= cnt_in;
         p1_ff      <= p1_in;
         p2_ff      <= p2_in;
         out_vld_ff <= out_vld_in;
         snd_ff     <= snd_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end

   assign out_empty = !out_vld_ff;
   assign out_data  = out_ff;

endmodule

// File: rtl/multi_voice_sample_mixer.sv
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Multi-voice one-shot PCM sample mixer with a register port for gain and
// sound boundaries.
// ----------------------------------------------------------------------------
// Requests enter through a two-entry command queue and are executed one at a
// time. In a frame the voice slots take turns on the single read port of the
// sample memory, followed by the registered read, the shared multiplier and
// the accumulator; then the result is scaled, clamped and registered. Results
// wait in an output register, so the queue keeps filling while a result is not
// yet popped. SAMPLE_DEPTH is a power of two; sample addresses wrap at it.
// Sample memory is not cleared by reset, so a sound must only play over
// addresses that have been loaded. Register writes are accepted in every cycle;
// a written value is registered before the execution unit uses it.
module multi_voice_sample_mixer #(
   parameter int VOICES       = mvsm_pkg::VOICES_DEF,
   parameter int NUM_SOUNDS   = mvsm_pkg::NUM_SOUNDS_DEF,
   parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  mvsm_pkg::req_type                   req_data,
   output logic                                empty,
   input  logic                                pop,
   output mvsm_pkg::rsp_type                   rsp_data,
   input  logic                                valid,
   output logic                                ready,
   input  logic [mvsm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mvsm_pkg::CSR_DATA_W-1:0]     csr_data
);

   mvsm_pkg::cfg_type      cfg_ff, cfg_in;
   mvsm_pkg::cmd_link_type cmd_link;
   logic                   cmd_pop;

   assign ready = 1'b1;

   // register writes are masked to each register's width
   always_comb begin
      cfg_in = cfg_ff;
      if (valid) begin
         case (csr_index)
            mvsm_pkg::CSR_GAIN:      cfg_in.gain      = csr_data[mvsm_pkg::GAIN_W-1:0];
            mvsm_pkg::CSR_S0_START:  cfg_in.start[0]  = csr_data[mvsm_pkg::START_W-1:0];
            mvsm_pkg::CSR_S0_LENGTH: cfg_in.length[0] = csr_data[mvsm_pkg::LENGTH_W-1:0];
            mvsm_pkg::CSR_S1_START:  cfg_in.start[1]  = csr_data[mvsm_pkg::START_W-1:0];
            mvsm_pkg::CSR_S1_LENGTH: cfg_in.length[1] = csr_data[mvsm_pkg::LENGTH_W-1:0];
            mvsm_pkg::CSR_S2_START:  cfg_in.start[2]  = csr_data[mvsm_pkg::START_W-1:0];
            mvsm_pkg::CSR_S2_LENGTH: cfg_in.length[2] = csr_data[mvsm_pkg::LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain <= mvsm_pkg::GAIN_RESET;
         for (int s = 0; s < mvsm_pkg::SOUND_SLOTS; s++) begin
            cfg_ff.start[s]  <= mvsm_pkg::START_RESET;
            cfg_ff.length[s] <= mvsm_pkg::LENGTH_RESET;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mvsm_front #(
      .NUM_SOUNDS (NUM_SOUNDS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_out  (cmd_link),
      .cmd_pop  (cmd_pop)
   );

   mvsm_back #(
      .VOICES       (VOICES),
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_in    (cmd_link),
      .cmd_pop   (cmd_pop),
      .out_empty (empty),
      .out_pop   (pop),
      .out_data  (rsp_data)
   );

endmodule

// File: bench/tb_multi_voice_sample_mixer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_voice_sample_mixer
// Self-checking bench for the four-voice sample mixer. Requests go in through
// the push/full queue and mixes come out through empty/pop. A mix tracker
// follows sample memory, voice slots and registers and predicts every frame.
// A directed start covers silent frames, ignored codes, zero-length sounds,
// clamping and dropped triggers. Random phases with new register settings
// and different stall patterns follow.
// ----------------------------------------------------------------------------
module tb_multi_voice_sample_mixer;

   localparam int VOICE_CNT       = mvsm_pkg::VOICES_DEF;
   localparam int PHASES          = 6;
   localparam int PHASE_ITEMS     = 250;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [1:0]                       ACT_UNUSED = 2'd3;
   localparam logic [mvsm_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   logic                             clock;
   logic                             reset;
   logic                             push;
   logic                             full;
   mvsm_pkg::req_type                req_data;
   logic                             empty;
   logic                             pop;
   mvsm_pkg::rsp_type                rsp_data;
   logic                             valid;
   logic                             ready;
   logic [mvsm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [mvsm_pkg::CSR_DATA_W-1:0]  csr_data;

   int send_idle     = 16;
   int recv_idle     = 70;
   int hold_left     = 0;
   int requests_sent = 0;

   class mix_tracker;
      bit [mvsm_pkg::SAMPLE_W-1:0] sample_mem [mvsm_pkg::SAMPLE_DEPTH_DEF];
      bit                          loaded     [mvsm_pkg::SAMPLE_DEPTH_DEF];
      bit                          voice_on   [VOICE_CNT];
      bit [1:0]                    voice_snd  [VOICE_CNT];
      bit [mvsm_pkg::LENGTH_W-1:0] voice_pos  [VOICE_CNT];
      bit [mvsm_pkg::GAIN_W-1:0]   gain;
      bit [mvsm_pkg::START_W-1:0]  snd_start  [mvsm_pkg::SOUND_SLOTS];
      bit [mvsm_pkg::LENGTH_W-1:0] snd_len    [mvsm_pkg::SOUND_SLOTS];
      mvsm_pkg::rsp_type           pending_mixes [$];
      int                          mixes_checked;
      int                          mismatches;
      int                          clamped;
      int                          dropped;

      function new();
         gain = mvsm_pkg::GAIN_RESET;
         foreach (snd_len[s]) begin
            snd_start[s] = mvsm_pkg::START_RESET;
            snd_len[s]   = mvsm_pkg::LENGTH_RESET;
         end
      endfunction

      function void write_register(logic [mvsm_pkg::CSR_INDEX_W-1:0] idx,
                                   logic [mvsm_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            mvsm_pkg::CSR_GAIN:      gain         = data[mvsm_pkg::GAIN_W-1:0];
            mvsm_pkg::CSR_S0_START:  snd_start[0] = data[mvsm_pkg::START_W-1:0];
            mvsm_pkg::CSR_S0_LENGTH: snd_len[0]   = data[mvsm_pkg::LENGTH_W-1:0];
            mvsm_pkg::CSR_S1_START:  snd_start[1] = data[mvsm_pkg::START_W-1:0];
            mvsm_pkg::CSR_S1_LENGTH: snd_len[1]   = data[mvsm_pkg::LENGTH_W-1:0];
            mvsm_pkg::CSR_S2_START:  snd_start[2] = data[mvsm_pkg::START_W-1:0];
            mvsm_pkg::CSR_S2_LENGTH: snd_len[2]   = data[mvsm_pkg::LENGTH_W-1:0];
            default: ;
         endcase
      endfunction

      // address wraps at the memory size
      function bit [mvsm_pkg::START_W-1:0] read_addr(int v);
         return snd_start[voice_snd[v]] + voice_pos[v][mvsm_pkg::START_W-1:0];
      endfunction

      function void note_request(mvsm_pkg::req_type r);
         longint            acc;
         longint            res;
         mvsm_pkg::rsp_type mix;
         bit                claimed;
         case (r.action)
            mvsm_pkg::ACT_FRAME: begin
               acc = 0;
               for (int v = 0; v < VOICE_CNT; v++) begin
                  if (voice_on[v]) begin
                     acc += longint'($signed(sample_mem[read_addr(v)])) * longint'(gain);
                     voice_pos[v] = voice_pos[v] + 1'b1;
                     if (voice_pos[v] >= snd_len[voice_snd[v]])
                        voice_on[v] = 1'b0;
                  end
               end
               res = acc >>> mvsm_pkg::MIX_SHIFT;
               if (res > mvsm_pkg::MIX_LIMIT) begin
                  res = mvsm_pkg::MIX_LIMIT;
                  clamped++;
               end else if (res < -mvsm_pkg::MIX_LIMIT) begin
                  res = -mvsm_pkg::MIX_LIMIT;
                  clamped++;
               end
               mix = '0;
               mix.mixed_sample = res[mvsm_pkg::SAMPLE_W-1:0];
               for (int v = 0; v < VOICE_CNT && v < mvsm_pkg::SHOWN_VOICES; v++)
                  mix.active_voices[v] = voice_on[v];
               pending_mixes.push_back(mix);
            end
            mvsm_pkg::ACT_TRIGGER: if (r.sound_sel < mvsm_pkg::NUM_SOUNDS_DEF) begin
               claimed = 1'b0;
               for (int v = 0; v < VOICE_CNT && !claimed; v++) begin
                  if (!voice_on[v] || voice_snd[v] == r.sound_sel) begin
                     voice_snd[v] = r.sound_sel;
                     voice_pos[v] = '0;
                     voice_on[v]  = 1'b1;
                     claimed      = 1'b1;
                  end
               end
               if (!claimed)
                  dropped++;
            end
            mvsm_pkg::ACT_LOAD: begin
               sample_mem[r.load_address] = r.load_data;
               loaded[r.load_address]     = 1'b1;
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string field, logic signed [16:0] want,
                                  logic signed [16:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         end
      endfunction

      function void check_mix(mvsm_pkg::rsp_type got);
         mvsm_pkg::rsp_type want;
         if (pending_mixes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: mix %0d / %b arrived with none expected", $time,
                        got.mixed_sample, got.active_voices);
            return;
         end
         want = pending_mixes.pop_front();
         mixes_checked++;
         compare_field("mixed_sample", want.mixed_sample, got.mixed_sample);
         compare_field("active_voices", want.active_voices, got.active_voices);
      endfunction
   endclass

   mix_tracker tracker = new();

   multi_voice_sample_mixer uut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .valid     (valid),
      .ready     (ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("timed out with %0d mixes outstanding", tracker.pending_mixes.size());
      $display("CHECK FAILED");
      $finish;
   end

   // mix receiver, with random stalls and the long hold-off
   initial begin
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty)
            tracker.check_mix(rsp_data);
         if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   function automatic mvsm_pkg::req_type any_request(logic [1:0] action);
      mvsm_pkg::req_type r;
      r.action       = action;
      r.sound_sel    = 2'($urandom_range(3));
      r.load_address = 16'($urandom());
      r.load_data    = 16'($urandom());
      return r;
   endfunction

   function automatic logic [15:0] random_sample();
      case ($urandom_range(7))
         0:       return 16'h7fff;
         1:       return 16'h8000;
         default: return 16'($urandom());
      endcase
   endfunction

   // push stays high when the next request follows at once
   task automatic push_request(mvsm_pkg::req_type r);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      tracker.note_request(r);
      requests_sent++;
   endtask

   task automatic send_load(logic [15:0] addr, logic [15:0] data);
      mvsm_pkg::req_type r;
      r = any_request(mvsm_pkg::ACT_LOAD);
      r.load_address = addr;
      r.load_data    = data;
      push_request(r);
   endtask

   task automatic send_trigger(logic [1:0] id);
      mvsm_pkg::req_type r;
      r = any_request(mvsm_pkg::ACT_TRIGGER);
      r.sound_sel = id;
      push_request(r);
   endtask

   // fill any sample a playing voice is about to read before the frame
   task automatic send_frame();
      for (int v = 0; v < VOICE_CNT; v++)
         if (tracker.voice_on[v] && !tracker.loaded[tracker.read_addr(v)])
            send_load(tracker.read_addr(v), random_sample());
      push_request(any_request(mvsm_pkg::ACT_FRAME));
   endtask

   task automatic wait_for_mixes();
      push <= 1'b0;
      while (tracker.pending_mixes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [mvsm_pkg::CSR_INDEX_W-1:0] idx,
                            logic [mvsm_pkg::CSR_DATA_W-1:0] data);
      valid     <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!ready) @(posedge clock);
      tracker.write_register(idx, data);
   endtask

   task automatic program_regs(logic [16:0] g, logic [16:0] st0, logic [16:0] ln0,
                               logic [16:0] st1, logic [16:0] ln1,
                               logic [16:0] st2, logic [16:0] ln2);
      csr_write(mvsm_pkg::CSR_GAIN, g);
      csr_write(mvsm_pkg::CSR_S0_START, st0);
      csr_write(mvsm_pkg::CSR_S0_LENGTH, ln0);
      csr_write(mvsm_pkg::CSR_S1_START, st1);
      csr_write(mvsm_pkg::CSR_S1_LENGTH, ln1);
      csr_write(mvsm_pkg::CSR_S2_START, st2);
      csr_write(mvsm_pkg::CSR_S2_LENGTH, ln2);
      valid <= 1'b0;
   endtask

   task automatic apply_phase_setting(int phase);
      logic [16:0] g;
      logic [16:0] st [mvsm_pkg::SOUND_SLOTS];
      logic [16:0] ln [mvsm_pkg::SOUND_SLOTS];
      // bits above the register width must be dropped
      g = 17'($urandom());
      if (phase == 1)
         g[mvsm_pkg::GAIN_W-1:0] = '0;
      else if (phase == 2 || phase == 5)
         g[mvsm_pkg::GAIN_W-1:0] = '1;
      foreach (st[s]) begin
         st[s] = 17'($urandom());
         case ($urandom_range(19))
            0:       ln[s] = 17'd0;
            1:       ln[s] = 17'h10000;
            2:       ln[s] = 17'($urandom());
            3, 4, 5: ln[s] = 17'($urandom_range(25, 200));
            default: ln[s] = 17'($urandom_range(1, 24));
         endcase
      end
      if (phase == 1) begin
         st[0][mvsm_pkg::START_W-1:0] = '1;
         st[1][mvsm_pkg::START_W-1:0] = '0;
      end
      if (phase == 2) begin
         ln[0] = 17'h10000;
         ln[1] = 17'd0;
         ln[2] = 17'd1;
      end
      if (phase == 0)
         csr_write(CSR_UNUSED, 17'($urandom()));
      program_regs(g, st[0], ln[0], st[1], ln[1], st[2], ln[2]);
   endtask

   task automatic run_random_phase(int phase);
      int pick;
      int s;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (phase == 4 && n == 60)
            hold_left = HOLD_OFF_CYCLES;
         if (phase == 2 && n == 140)
            wait_for_mixes();
         pick = $urandom_range(99);
         if (pick < 45) begin
            send_frame();
         end else if (pick < 72) begin
            if ($urandom_range(9) == 0)
               send_trigger(2'(mvsm_pkg::SOUND_SLOTS));
            else
               send_trigger(2'($urandom_range(mvsm_pkg::SOUND_SLOTS - 1)));
         end else if (pick < 83) begin
            send_load(16'($urandom()), random_sample());
         end else if (pick < 94) begin
            // overwrite samples that are being played
            s = $urandom_range(mvsm_pkg::SOUND_SLOTS - 1);
            send_load(tracker.snd_start[s] + 16'($urandom_range(40)), random_sample());
         end else begin
            push_request(any_request(ACT_UNUSED));
         end
      end
   endtask

   initial begin
      reset     <= 1'b1;
      push      <= 1'b0;
      req_data  <= '0;
      valid     <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full gain, sound zero wraps the top address, sound one has zero length
      program_regs(17'd32767, 17'hffff, 17'd2, 17'd100, 17'd0, 17'd200, 17'd3);
      send_frame();
      push_request(any_request(ACT_UNUSED));
      send_trigger(2'(mvsm_pkg::SOUND_SLOTS));
      send_load(16'hffff, 16'h7fff);
      send_load(16'h0000, 16'h7fff);
      send_load(16'd100, 16'h7fff);
      send_load(16'd200, 16'h8000);
      send_load(16'd201, 16'h7fff);
      send_load(16'd202, 16'h7fff);
      send_trigger(2'd1);
      send_trigger(2'd2);
      send_frame();
      send_trigger(2'd2);
      send_trigger(2'd1);
      send_trigger(2'd0);
      // all four slots busy, mix clamps
      send_frame();
      send_trigger(2'd0);
      // sound one is not playing and no slot is idle
      send_trigger(2'd1);
      send_frame();
      send_frame();

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_mixes();
         apply_phase_setting(phase);
         send_idle = (phase < 2) ? 16 : (phase < 4) ? 70 : 0;
         recv_idle = (phase < 2) ? 70 : (phase < 4) ? 16 : 0;
         run_random_phase(phase);
      end
      wait_for_mixes();

      $display("mixer run: %0d requests, %0d mixes checked, %0d clamped, %0d triggers dropped",
               requests_sent, tracker.mixes_checked, tracker.clamped, tracker.dropped);
      $display("register settings: %0d, zero and full gain, wrapped starts, odd lengths",
               PHASES + 1);
      if (tracker.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", tracker.mismatches);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
